/* sv/mlp2_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mlp2_pkg;

  localparam int MaxInputsDef  = 32;
  localparam int MaxHiddenDef  = 16;
  localparam int MaxOutputsDef = 2;
  localparam int TableSize     = 1024;
  localparam int AccW          = 40;
  localparam logic [63:0] ExpStep = 64'd2114190001;

  typedef struct packed {
    logic               opcode;
    logic [9:0]         index;
    logic signed [15:0] value;
    logic               last;
  } mlp2_in_t;

  typedef struct packed {
    logic        output_index;
    logic [18:0] output_value;
    logic        last_output;
  } mlp2_out_t;

  typedef enum logic [1:0] {
    CFG_INPUTS  = 2'd0,
    CFG_HIDDEN  = 2'd1,
    CFG_OUTPUTS = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_H_RUN, S_H_DRAIN, S_H_LOOK, S_H_WRITE,
    S_O_RUN, S_O_DRAIN, S_O_LOOK, S_O_EMIT
  } state_e;

  typedef logic [15:0] sig_table_t [TableSize];

  function automatic logic signed [AccW-1:0] sat_add(logic signed [AccW-1:0] a,
                                                     logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end
    return s[AccW-1:0];
  endfunction

  // e^(-m/64) recurrence, then 2^47/(2^31+p) by shift-subtract
  function automatic sig_table_t build_sig_table();
    sig_table_t  t;
    logic [63:0] p [513];
    logic [63:0] d, num, rem, q;
    int          i, m, b;
    p[0] = 64'd1 << 31;
    for (m = 0; m < 512; m++) begin
      p[m+1] = (p[m] * ExpStep + (64'd1 << 30)) >> 31;
    end
    for (i = 0; i < TableSize; i++) begin
      m   = (i >= 512) ? i - 512 : 512 - i;
      d   = (64'd1 << 31) + p[m];
      num = (64'd1 << 47) + (d >> 1);
      rem = '0;
      q   = '0;
      for (b = 48; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        q   = q << 1;
        if (rem >= d) begin
          rem  = rem - d;
          q[0] = 1'b1;
        end
      end
      if (i < 512) q = 64'd65536 - q;
      if (q > 64'd65535) q = 64'd65535;
      t[i] = q[15:0];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

/* sv/mlp2_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module mlp2_ram #(
  parameter int Width = 16,
  parameter int Depth = 32,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* sv/mlp_two_layer_sigmoid_forward_unit.sv */
// Two-layer sigmoid perceptron, inference.
// in channel (in_valid_i/in_ready_o, in_data_i): opcode 0 writes a parameter
// word, opcode 1 stores an input element; last on opcode 1 starts a run.
// out channel (out_valid_o/out_ready_i, out_data_o): one result per output unit.
// cfg channel: register index and data, always ready; write only when idle.
// Requests are taken one per cycle while idle; a run holds in_ready_o low.
// One shared accumulator, fed through the multiply stage from the parameter
// RAM, takes one product per cycle while a unit's sum runs. The single output
// register holds a result until taken; further results wait. Reset clears
// control and the sizes to 32/16/2; RAM contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module mlp_two_layer_sigmoid_forward_unit
  import mlp2_pkg::*;
#(
  parameter int MAX_INPUTS  = MaxInputsDef,
  parameter int MAX_HIDDEN  = MaxHiddenDef,
  parameter int MAX_OUTPUTS = MaxOutputsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire mlp2_in_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output mlp2_out_t       out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);
  localparam int StoreDepth = MAX_INPUTS * MAX_HIDDEN + MAX_HIDDEN
                              + MAX_HIDDEN * MAX_OUTPUTS + MAX_OUTPUTS;
  localparam int AW   = $clog2(StoreDepth);
  localparam int IAW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int HAW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int MaxN = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
  localparam int NW   = $clog2(MaxN + 1);
  localparam int KW   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int OW   = $clog2(MAX_OUTPUTS + 1);
  localparam sig_table_t SigRom = build_sig_table();

  state_e state_q, state_d;
  logic [5:0] cfg_in_q;
  logic [4:0] cfg_hid_q;
  logic [1:0] cfg_out_q;
  logic [NW-1:0] ni, nh, n_cur, c_q, c_d;
  logic [OW-1:0] no;
  logic [NW-1:0] unit_q, unit_d;
  logic [KW-1:0] k_q, k_d;
  logic [AW-1:0] hb_q, hb_d, onh_q, onh_d, wbase_q, wbase_d, obias_q, obias_d;
  logic v1_q, v1_d, b1_q, b1_d, v2_q, b2_q;
  logic signed [AccW-1:0] term_q, acc_q;
  logic [15:0] sig_q;
  logic [9:0]  sig_idx;
  logic        ophase;
  logic        issue;
  logic [AW-1:0] p_raddr;
  logic [15:0] p_rd, x_rd, h_rd;
  logic        p_we, x_we, h_we;
  logic        out_load;
  logic        in_acc;

  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign ophase      = (state_q == S_O_RUN) || (state_q == S_O_DRAIN)
                    || (state_q == S_O_LOOK) || (state_q == S_O_EMIT);

  always_comb begin
    if (cfg_in_q == '0) ni = NW'(1);
    else if (32'(cfg_in_q) > MAX_INPUTS) ni = NW'(MAX_INPUTS);
    else ni = NW'(cfg_in_q);
    if (cfg_hid_q == '0) nh = NW'(1);
    else if (32'(cfg_hid_q) > MAX_HIDDEN) nh = NW'(MAX_HIDDEN);
    else nh = NW'(cfg_hid_q);
    if (cfg_out_q == '0) no = OW'(1);
    else if (32'(cfg_out_q) > MAX_OUTPUTS) no = OW'(MAX_OUTPUTS);
    else no = OW'(cfg_out_q);
  end

  assign n_cur = ophase ? nh : ni;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_in_q  <= 6'd32;
      cfg_hid_q <= 5'd16;
      cfg_out_q <= 2'd2;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_INPUTS:  cfg_in_q  <= cfg_data_i[5:0];
        CFG_HIDDEN:  cfg_hid_q <= cfg_data_i[4:0];
        CFG_OUTPUTS: cfg_out_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign p_we = in_acc && !in_data_i.opcode && (32'(in_data_i.index) < StoreDepth);
  assign x_we = in_acc && in_data_i.opcode && (32'(in_data_i.index) < MAX_INPUTS);
  assign h_we = (state_q == S_H_WRITE);
  assign issue = (state_q == S_H_RUN) || (state_q == S_O_RUN);

  always_comb begin
    if (c_q == '0) begin
      p_raddr = ophase ? (obias_q + AW'(k_q)) : (hb_q + AW'(unit_q));
    end else begin
      p_raddr = wbase_q + AW'(c_q) - AW'(1);
    end
  end

  mlp2_ram #(.Width(16), .Depth(StoreDepth)) u_param_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(AW'(in_data_i.index)),
    .wdata_i(in_data_i.value),
    .raddr_i(p_raddr),
    .rdata_o(p_rd)
  );

  mlp2_ram #(.Width(16), .Depth(MAX_INPUTS)) u_input_ram (
    .clk_i  (clk_i),
    .we_i   (x_we),
    .waddr_i(IAW'(in_data_i.index)),
    .wdata_i(in_data_i.value),
    .raddr_i(IAW'(c_q - NW'(1))),
    .rdata_o(x_rd)
  );

  mlp2_ram #(.Width(16), .Depth(MAX_HIDDEN)) u_hidden_ram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(HAW'(unit_q)),
    .wdata_i(sig_q),
    .raddr_i(HAW'(c_q - NW'(1))),
    .rdata_o(h_rd)
  );

  // multiply stage and accumulate stage
  logic signed [31:0] prod_h;
  logic signed [32:0] prod_o;
  logic signed [AccW-1:0] term_d;
  always_comb begin
    prod_h = $signed(p_rd) * $signed(x_rd);
    prod_o = $signed(p_rd) * $signed({1'b0, h_rd});
    if (b1_q) begin
      term_d = ophase ? {{8{p_rd[15]}}, p_rd, 16'd0} : {{12{p_rd[15]}}, p_rd, 12'd0};
    end else begin
      term_d = ophase ? AccW'(prod_o) : AccW'(prod_h);
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
    if (v2_q) begin
      acc_q <= b2_q ? term_q : sat_add(acc_q, term_q);
    end
    sig_q <= SigRom[sig_idx];
  end

  logic signed [AccW-1:0] acc_off;
  always_comb begin
    if (ophase) begin
      acc_off = acc_q + (AccW'(1) <<< 31);
      if (acc_q < -(AccW'(1) <<< 31)) sig_idx = '0;
      else if (acc_q >= (AccW'(1) <<< 31)) sig_idx = '1;
      else sig_idx = acc_off[31:22];
    end else begin
      acc_off = acc_q + (AccW'(1) <<< 27);
      if (acc_q < -(AccW'(1) <<< 27)) sig_idx = '0;
      else if (acc_q >= (AccW'(1) <<< 27)) sig_idx = '1;
      else sig_idx = acc_off[27:18];
    end
  end

  always_comb begin
    state_d = state_q;
    c_d     = c_q;
    unit_d  = unit_q;
    k_d     = k_q;
    hb_d    = hb_q;
    onh_d   = onh_q;
    wbase_d = wbase_q;
    obias_d = obias_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.opcode && in_data_i.last) state_d = S_SETUP;
      end
      S_SETUP: begin
        hb_d    = AW'(ni) * AW'(nh);
        onh_d   = AW'(no) * AW'(nh);
        unit_d  = '0;
        wbase_d = '0;
        c_d     = '0;
        state_d = S_H_RUN;
      end
      S_H_RUN, S_O_RUN: begin
        if (c_q == n_cur) begin
          state_d = (state_q == S_H_RUN) ? S_H_DRAIN : S_O_DRAIN;
        end else begin
          c_d = c_q + NW'(1);
        end
      end
      S_H_DRAIN: if (!v1_q && !v2_q) state_d = S_H_LOOK;
      S_O_DRAIN: if (!v1_q && !v2_q) state_d = S_O_LOOK;
      S_H_LOOK: state_d = S_H_WRITE;
      S_O_LOOK: state_d = S_O_EMIT;
      S_H_WRITE: begin
        c_d = '0;
        if (unit_q == nh - NW'(1)) begin
          k_d     = '0;
          wbase_d = hb_q + AW'(nh);
          obias_d = hb_q + AW'(nh) + onh_q;
          state_d = S_O_RUN;
        end else begin
          unit_d  = unit_q + NW'(1);
          wbase_d = wbase_q + AW'(ni);
          state_d = S_H_RUN;
        end
      end
      S_O_EMIT: begin
        if (!out_valid_o || out_ready_i) begin
          c_d = '0;
          if (OW'(k_q) == no - OW'(1)) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + KW'(1);
            wbase_d = wbase_q + AW'(nh);
            state_d = S_O_RUN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    v1_d     = issue;
    b1_d     = issue && (c_q == '0);
    out_load = (state_q == S_O_EMIT) && (!out_valid_o || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      c_q         <= '0;
      unit_q      <= '0;
      k_q         <= '0;
      hb_q        <= '0;
      onh_q       <= '0;
      wbase_q     <= '0;
      obias_q     <= '0;
      v1_q        <= 1'b0;
      b1_q        <= 1'b0;
      v2_q        <= 1'b0;
      b2_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      unit_q  <= unit_d;
      k_q     <= k_d;
      hb_q    <= hb_d;
      onh_q   <= onh_d;
      wbase_q <= wbase_d;
      obias_q <= obias_d;
      v1_q    <= v1_d;
      b1_q    <= b1_d;
      v2_q    <= v1_q;
      b2_q    <= b1_q;
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_o.output_index <= k_q[0];
      out_data_o.output_value <= (19'(sig_q) << 3) - 19'(sig_q);
      out_data_o.last_output  <= (OW'(k_q) == no - OW'(1));
    end
  end
endmodule
`default_nettype wire
